// File: hw/rtl/slc_pkg.sv
// Shared types and character constants for the source line classifier.
package slc_pkg;

    // Fixed width of the reported totals on the output ports.
    localparam int unsigned OUT_WIDTH = 32;

    // Characters that steer the line state.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Where the current line stands in its leading text.
    typedef enum logic [4:0] {
        PH_LEAD    = 5'b00001,
        PH_SLASH   = 5'b00010,
        PH_BLOCK   = 5'b00100,
        PH_LINECOM = 5'b01000,
        PH_CODE    = 5'b10000
    } t_phase;

    // Per-file line state held by the classifier.
    typedef struct packed {
        logic   block_open;
        logic   line_has_text;
        t_phase phase;
        logic   last_was_star;
        logic   close_seen;
    } t_line_state;

    // Increments for the three totals caused by one item.
    typedef struct packed {
        logic [1:0] blank;
        logic       code;
        logic       comment;
    } t_incr;

endpackage

// File: hw/rtl/slc_line_fsm.sv
// Per-byte line state and line classification for the source line classifier.
module slc_line_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_end_of_file,
    output slc_pkg::t_incr       o_incr
);

    slc_pkg::t_line_state r_state;
    slc_pkg::t_line_state n_state;

    logic w_is_nl;
    logic w_finish;
    logic w_is_ws;
    logic w_blank;
    logic w_comment;

    assign w_is_nl  = !i_end_of_file && (i_ch == slc_pkg::CH_LF);
    assign w_finish = w_is_nl || (i_end_of_file && r_state.line_has_text);
    assign w_is_ws  = (i_ch == slc_pkg::CH_SPACE) ||
                      ((i_ch >= slc_pkg::CH_TAB) && (i_ch <= slc_pkg::CH_CR));

    assign w_blank   = (r_state.phase == slc_pkg::PH_LEAD);
    assign w_comment = !w_blank && (r_state.block_open ||
                                    (r_state.phase == slc_pkg::PH_BLOCK) ||
                                    (r_state.phase == slc_pkg::PH_LINECOM));

    always_comb begin
        o_incr.blank   = {1'b0, w_finish && w_blank} + {1'b0, i_end_of_file};
        o_incr.comment = w_finish && w_comment;
        o_incr.code    = w_finish && !w_blank && !w_comment;
    end

    always_comb begin
        n_state = r_state;
        if (w_finish) begin
            // A closed block ends the open comment; a line opening one leaves it open.
            if (!w_blank) begin
                if (r_state.block_open) begin
                    n_state.block_open = !r_state.close_seen;
                end else if (r_state.phase == slc_pkg::PH_BLOCK) begin
                    n_state.block_open = !r_state.close_seen;
                end
            end
            n_state.line_has_text = 1'b0;
            n_state.phase         = slc_pkg::PH_LEAD;
            n_state.last_was_star = 1'b0;
            n_state.close_seen    = 1'b0;
        end else if (!i_end_of_file) begin
            n_state.line_has_text = 1'b1;
            n_state.close_seen    = r_state.close_seen ||
                                    ((i_ch == slc_pkg::CH_SLASH) && r_state.last_was_star);
            n_state.last_was_star = (i_ch == slc_pkg::CH_STAR);
            unique case (r_state.phase) inside
                slc_pkg::PH_LEAD: begin
                    if (i_ch == slc_pkg::CH_SLASH) begin
                        n_state.phase = slc_pkg::PH_SLASH;
                    end else if (!w_is_ws) begin
                        n_state.phase = slc_pkg::PH_CODE;
                    end
                end
                slc_pkg::PH_SLASH: begin
                    if (i_ch == slc_pkg::CH_STAR) begin
                        n_state.phase = slc_pkg::PH_BLOCK;
                    end else if (i_ch == slc_pkg::CH_SLASH) begin
                        n_state.phase = slc_pkg::PH_LINECOM;
                    end else begin
                        n_state.phase = slc_pkg::PH_CODE;
                    end
                end
                slc_pkg::PH_BLOCK, slc_pkg::PH_LINECOM, slc_pkg::PH_CODE: begin
                    n_state.phase = r_state.phase;
                end
                default: begin
                    n_state.phase = slc_pkg::PH_LEAD;
                end
            endcase
        end
        if (i_end_of_file) begin
            n_state.block_open    = 1'b0;
            n_state.line_has_text = 1'b0;
            n_state.phase         = slc_pkg::PH_LEAD;
            n_state.last_was_star = 1'b0;
            n_state.close_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.block_open    <= 1'b0;
            r_state.line_has_text <= 1'b0;
            r_state.phase         <= slc_pkg::PH_LEAD;
            r_state.last_was_star <= 1'b0;
            r_state.close_seen    <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/source_line_classifier.sv
// Top level of the source line classifier: input register, line state and saturating totals.
//
// The block takes source text one byte per transfer and sorts every line that a line feed
// ends as blank (whitespace only), comment (a block comment is open, or the first text is
// a double slash or slash-star) or code. An end-of-file transfer finishes any unfinished
// line, adds one further blank line, clears the per-file state and produces one result
// transfer carrying the three running totals; byte transfers produce no result. The totals
// persist across files and stick at their largest value; with COUNT_WIDTH above 32 the
// ports carry the low 32 bits. One item is taken every cycle while the input side does not
// stall: a byte passes from the input register through a single level of line-state logic into
// the state and count registers, and an end-of-file result passes from the input register
// into the result register. The input side only stalls when an end-of-file item must load the
// result register while a previous result is still waiting to be taken.
module source_line_classifier #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_ch,
    input  logic                              i_end_of_file,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [slc_pkg::OUT_WIDTH-1:0]     o_blank_count,
    output logic [slc_pkg::OUT_WIDTH-1:0]     o_code_count,
    output logic [slc_pkg::OUT_WIDTH-1:0]     o_comment_count
);

    localparam int unsigned OW = slc_pkg::OUT_WIDTH;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eof;

    // Running totals.
    logic [COUNT_WIDTH-1:0] r_blank;
    logic [COUNT_WIDTH-1:0] r_code;
    logic [COUNT_WIDTH-1:0] r_comment;
    logic [COUNT_WIDTH-1:0] n_blank;
    logic [COUNT_WIDTH-1:0] n_code;
    logic [COUNT_WIDTH-1:0] n_comment;

    // Result register.
    logic          r_out_valid;
    logic [OW-1:0] r_out_blank;
    logic [OW-1:0] r_out_code;
    logic [OW-1:0] r_out_comment;

    logic           w_step;
    slc_pkg::t_incr w_incr;

    // Adds at most two and sticks at the all-ones value.
    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic [1:0]             inc
    );
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, cnt} + {{(COUNT_WIDTH - 1){1'b0}}, inc};
        if (sum[COUNT_WIDTH]) begin
            sat_add = {COUNT_WIDTH{1'b1}};
        end else begin
            sat_add = sum[COUNT_WIDTH-1:0];
        end
    endfunction

    // Fits a total to the port width: low bits when wider, zero-extended when narrower.
    function automatic logic [OW-1:0] to_port(input logic [COUNT_WIDTH-1:0] cnt);
        logic [OW+COUNT_WIDTH-1:0] ext;
        ext     = {{OW{1'b0}}, cnt};
        to_port = ext[OW-1:0];
    endfunction

    // A byte always moves on; an end-of-file item needs room in the result register.
    assign w_step  = r_in_valid && (!r_eof || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    slc_line_fsm u_line_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_ch          (r_ch),
        .i_end_of_file (r_eof),
        .o_incr        (w_incr)
    );

    always_comb begin
        n_blank   = sat_add(r_blank, w_incr.blank);
        n_code    = sat_add(r_code, {1'b0, w_incr.code});
        n_comment = sat_add(r_comment, {1'b0, w_incr.comment});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch  <= i_ch;
            r_eof <= i_end_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank   <= '0;
            r_code    <= '0;
            r_comment <= '0;
        end else if (w_step) begin
            r_blank   <= n_blank;
            r_code    <= n_code;
            r_comment <= n_comment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_eof) begin
            r_out_blank   <= to_port(n_blank);
            r_out_code    <= to_port(n_code);
            r_out_comment <= to_port(n_comment);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_blank_count   = r_out_blank;
    assign o_code_count    = r_out_code;
    assign o_comment_count = r_out_comment;

endmodule
